[sv/wtsl_pkg.sv]
// Shared constants for the wavelength to linear sRGB converter: lobe fit,
// exponent series, reciprocal constants, color matrix and pipeline depths.
// No dependencies.
package wtsl_pkg;

   localparam int WAVE_W             = 14;
   localparam int WAVE_FRAC_BITS_DEF = 4;
   localparam int OUT_BITS_DEF       = 16;

   localparam int NUM_LOBES = 7;
   localparam int Q30_W     = 31;   // lobe value, 0 to 1.0 in Q30
   localparam int T_W       = 21;   // lobe distance t, Q16
   localparam int U_W       = 21;   // t*t/2 below the cutoff, Q16

   // lobes 0..2 feed X, 3..4 feed Y, 5..6 feed Z
   localparam logic [12:0] LOBE_CENTRE10 [NUM_LOBES] =
      '{13'd4420, 13'd5998, 13'd5011, 13'd5688, 13'd5309, 13'd4370, 13'd4590};
   localparam logic [9:0] LOBE_SCALE_LO [NUM_LOBES] =
      '{10'd624, 10'd264, 10'd490, 10'd213, 10'd613, 10'd845, 10'd385};
   localparam logic [9:0] LOBE_SCALE_HI [NUM_LOBES] =
      '{10'd374, 10'd323, 10'd382, 10'd247, 10'd322, 10'd278, 10'd725};
   localparam logic signed [12:0] LOBE_AMP [NUM_LOBES] =
      '{13'sd362, 13'sd1056, -13'sd65, 13'sd821, 13'sd286, 13'sd1217, 13'sd681};

   localparam logic signed [25:0] XYZ_TO_RGB [3][3] = '{
      '{ 26'sd32406255, -26'sd15372080, -26'sd4986286},
      '{-26'sd9689307,   26'sd18757561,  26'sd415175},
      '{ 26'sd557101,   -26'sd2040211,   26'sd10569959}};

   // exp(-r) series; division by k done as (v * HORNER_MUL) >> HORNER_SHIFT
   localparam int SERIES_TERMS = 14;
   localparam logic [30:0] HORNER_MUL [SERIES_TERMS] = '{
      31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
      31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
      31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766,
      31'd1321528399, 31'd1227133514};
   localparam int HORNER_SHIFT [SERIES_TERMS] = '{
      30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34, 34, 34};

   localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;
   localparam int          EXP_CUTOFF = 24;
   localparam int          EXP_STEPS  = EXP_CUTOFF - 1;

   // reciprocals for exact floor division by constants
   localparam logic [32:0] RECIP_3125  = 33'd5629499535;
   localparam int          SHIFT_3125  = 44;
   localparam logic [38:0] RECIP_125   = 39'd281474976711;
   localparam int          SHIFT_125   = 45;
   localparam logic [47:0] RECIP_78125 = 48'd236118324143483;
   localparam int          SHIFT_78125 = 64;

   localparam logic signed [59:0] SAT_LIMIT    = 60'sd10737418235000000;
   localparam logic signed [59:0] MAT_HALF     = 60'sd5000000;
   localparam logic [42:0]        AMP_HALF     = 43'd500;

   localparam int CMUL_LAT = 2;
   localparam int LOBE_LAT = 1 + 1 + CMUL_LAT + 1 + 2 * SERIES_TERMS + EXP_STEPS;
   localparam int POST_LAT = 1 + 1 + CMUL_LAT + 1 + 1 + 1 + 1 + CMUL_LAT + 1;

endpackage

[sv/wtsl_cmul.sv]
// Pipelined multiply by a constant reciprocal and shift: floor division by a
// constant in two stages (partial products, then sum). Uses no package.
module wtsl_cmul #(
   parameter int            IN_W  = 32,
   parameter int            M_W   = 33,
   parameter logic [M_W-1:0] MUL  = '1,
   parameter int            SHIFT = 44,
   parameter int            OUT_W = 21
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [IN_W-1:0]  din,
   output logic [OUT_W-1:0] dout
);

   localparam int VLo = (IN_W + 1) / 2;
   localparam int VHi = IN_W - VLo;
   localparam int MLo = (M_W + 1) / 2;
   localparam int MHi = M_W - MLo;
   localparam int PW  = IN_W + M_W;
   localparam logic [MLo-1:0] MulLo = MUL[MLo-1:0];
   localparam logic [MHi-1:0] MulHi = MUL[M_W-1:MLo];

   logic [VLo+MLo-1:0] pll_ff, pll_in;
   logic [VLo+MHi-1:0] plh_ff, plh_in;
   logic [VHi+MLo-1:0] phl_ff, phl_in;
   logic [VHi+MHi-1:0] phh_ff, phh_in;
   logic [PW-1:0]      prod;
   logic [OUT_W-1:0]   q_ff, q_in;

   always_comb begin
      pll_in = din[VLo-1:0] * MulLo;
      plh_in = din[VLo-1:0] * MulHi;
      phl_in = din[IN_W-1:VLo] * MulLo;
      phh_in = din[IN_W-1:VLo] * MulHi;
   end

   always_comb begin
      prod = (PW'(phh_ff) << (VLo + MLo)) + (PW'(phl_ff) << VLo)
           + (PW'(plh_ff) << MLo) + PW'(pll_ff);
      q_in = prod[SHIFT +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phl_ff <= phl_in;
         phh_ff <= phh_in;
         q_ff   <= q_in;
      end
   end

   assign dout = q_ff;

endmodule

[sv/wtsl_exp.sv]
// exp(-u) in Q30 for u in Q16: series stages for the fraction, then one
// stage per whole unit of u. Depends on wtsl_pkg.
module wtsl_exp (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [wtsl_pkg::U_W-1:0]     u,
   input  logic                         zero,
   output logic [wtsl_pkg::Q30_W-1:0]   value
);

   localparam int Terms = wtsl_pkg::SERIES_TERMS;
   localparam int Steps = wtsl_pkg::EXP_STEPS;

   logic [29:0] hv_ff [Terms];
   logic [29:0] hv_in [Terms];
   logic [30:0] hp_ff [Terms];
   logic [30:0] hp_in [Terms];
   logic [29:0] ra_ff [Terms];
   logic [29:0] rb_ff [Terms];
   logic [4:0]  na_ff [Terms];
   logic [4:0]  nb_ff [Terms];
   logic        za_ff [Terms];
   logic        zb_ff [Terms];
   logic [30:0] e_ff  [Steps];
   logic [30:0] e_in  [Steps];
   logic [4:0]  ne_ff [Steps];
   logic        ze_ff [Steps];

   genvar j, i;

   // Horner series, k counts down from the last term
   for (j = 0; j < Terms; j++) begin : g_term
      localparam int K  = Terms - j;
      localparam int Sh = wtsl_pkg::HORNER_SHIFT[K-1];
      logic [29:0] r_src;
      logic [30:0] p_src;
      logic [4:0]  n_src;
      logic        z_src;
      logic [60:0] prod_a;
      logic [60:0] prod_b;
      logic [29:0] quo;

      if (j == 0) begin : g_first
         assign r_src = {u[15:0], 14'd0};
         assign p_src = 31'h4000_0000;
         assign n_src = u[20:16];
         assign z_src = zero;
      end else begin : g_next
         assign r_src = rb_ff[j-1];
         assign p_src = hp_ff[j-1];
         assign n_src = nb_ff[j-1];
         assign z_src = zb_ff[j-1];
      end

      assign prod_a   = r_src * p_src;
      assign hv_in[j] = prod_a[59:30];
      assign prod_b   = hv_ff[j] * wtsl_pkg::HORNER_MUL[K-1];
      assign quo      = 30'(prod_b >> Sh);
      assign hp_in[j] = 31'h4000_0000 - 31'(quo);

      always_ff @(posedge clock) begin
         if (adv) begin
            hv_ff[j] <= hv_in[j];
            ra_ff[j] <= r_src;
            na_ff[j] <= n_src;
            za_ff[j] <= z_src;
            hp_ff[j] <= hp_in[j];
            rb_ff[j] <= ra_ff[j];
            nb_ff[j] <= na_ff[j];
            zb_ff[j] <= za_ff[j];
         end
      end
   end

   // one rounded multiply by exp(-1) per whole unit of u
   for (i = 0; i < Steps; i++) begin : g_unit
      logic [30:0] e_src;
      logic [4:0]  n_src;
      logic        z_src;
      logic [59:0] prod_e;
      logic [59:0] rnd;

      if (i == 0) begin : g_first
         assign e_src = hp_ff[Terms-1];
         assign n_src = nb_ff[Terms-1];
         assign z_src = zb_ff[Terms-1];
      end else begin : g_next
         assign e_src = e_ff[i-1];
         assign n_src = ne_ff[i-1];
         assign z_src = ze_ff[i-1];
      end

      assign prod_e  = e_src * wtsl_pkg::EXP_M1_Q30;
      assign rnd     = prod_e + 60'h2000_0000;
      assign e_in[i] = (n_src > 5'(i)) ? 31'(rnd >> 30) : e_src;

      always_ff @(posedge clock) begin
         if (adv) begin
            e_ff[i]  <= e_in[i];
            ne_ff[i] <= n_src;
            ze_ff[i] <= z_src;
         end
      end
   end

   // far tail contributes nothing
   assign value = ze_ff[Steps-1] ? '0 : e_ff[Steps-1];

endmodule

[sv/wtsl_lobe.sv]
// One Gaussian lobe of the matching-function fit: distance, scale, square,
// then exp(-t*t/2) in Q30. Depends on wtsl_pkg, wtsl_cmul and wtsl_exp.
module wtsl_lobe #(
   parameter int WAVE_FRAC_BITS = wtsl_pkg::WAVE_FRAC_BITS_DEF,
   parameter int LOBE           = 0
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [wtsl_pkg::WAVE_W-1:0]   wavelength,
   output logic [wtsl_pkg::Q30_W-1:0]    value
);

   localparam int AW    = 18;
   localparam int CW    = 13 + WAVE_FRAC_BITS;
   localparam int MagW  = (CW > AW) ? CW : AW;
   localparam int XW    = MagW + 10;
   localparam int XLimW = 20 + WAVE_FRAC_BITS;
   localparam int PadW  = 11 - WAVE_FRAC_BITS;
   localparam logic [MagW-1:0] Centre =
      MagW'(wtsl_pkg::LOBE_CENTRE10[LOBE]) << WAVE_FRAC_BITS;

   logic [AW-1:0]    a10;
   logic [MagW-1:0]  mag_ff, mag_in;
   logic [9:0]       scale_ff, scale_in;
   logic [XW-1:0]    x;
   logic [XLimW-1:0] xl_ff;
   logic             big_ff;
   logic [31:0]      num;
   logic [1:0]       bd_ff;
   logic [wtsl_pkg::T_W-1:0] t;
   logic [41:0]      sq;
   logic [42:0]      sqr;
   logic [25:0]      uf;
   logic [wtsl_pkg::U_W-1:0] u_ff;
   logic             zero_ff, zero_in;

   always_comb begin
      a10 = wavelength * 5'd10;
      // exactly at the centre the upper scale applies
      if (MagW'(a10) < Centre) begin
         mag_in   = Centre - MagW'(a10);
         scale_in = wtsl_pkg::LOBE_SCALE_LO[LOBE];
      end else begin
         mag_in   = MagW'(a10) - Centre;
         scale_in = wtsl_pkg::LOBE_SCALE_HI[LOBE];
      end
   end

   assign x   = mag_ff * scale_ff;
   assign num = 32'({xl_ff, {PadW{1'b0}}}) + 32'd1562;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff   <= mag_in;
         scale_ff <= scale_in;
         xl_ff    <= x[XLimW-1:0];
         big_ff   <= |x[XW-1:XLimW];
         bd_ff    <= {bd_ff[0], big_ff};
         u_ff     <= uf[wtsl_pkg::U_W-1:0];
         zero_ff  <= zero_in;
      end
   end

   wtsl_cmul #(
      .IN_W  (32),
      .M_W   (33),
      .MUL   (wtsl_pkg::RECIP_3125),
      .SHIFT (wtsl_pkg::SHIFT_3125),
      .OUT_W (wtsl_pkg::T_W)
   ) u_tdiv (
      .clock (clock),
      .adv   (adv),
      .din   (num),
      .dout  (t)
   );

   always_comb begin
      sq      = t * t;
      sqr     = 43'(sq) + 43'd65536;
      uf      = sqr[42:17];
      // a large distance is past the cutoff whatever its exact value
      zero_in = bd_ff[1] || (uf >= 26'(wtsl_pkg::EXP_CUTOFF << 16));
   end

   wtsl_exp u_exp (
      .clock (clock),
      .adv   (adv),
      .u     (u_ff),
      .zero  (zero_ff),
      .value (value)
   );

endmodule

[sv/wavelength_to_srgb_linear_core.sv]
// Wavelength to linear sRGB: seven lobe pipelines, XYZ rounding, matrix, clamp.
// Requests pass through the lobe pipelines, then the XYZ and matrix stages.
// Throughput: one request per cycle while the result is not stalled.
// A stalled result freezes the whole pipeline; it holds, nothing is dropped.
// Reset clears the valid bits; data registers are not reset.
// Depends on wtsl_pkg, wtsl_lobe and wtsl_cmul.
module wavelength_to_srgb_linear_core #(
   parameter int WAVE_FRAC_BITS = wtsl_pkg::WAVE_FRAC_BITS_DEF,
   parameter int OUT_BITS       = wtsl_pkg::OUT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [wtsl_pkg::WAVE_W-1:0]  req_wavelength,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [OUT_BITS-1:0]          rsp_red,
   output logic [OUT_BITS-1:0]          rsp_green,
   output logic [OUT_BITS-1:0]          rsp_blue
);

   localparam int Lat   = wtsl_pkg::LOBE_LAT + wtsl_pkg::POST_LAT;
   localparam int Lobes = wtsl_pkg::NUM_LOBES;
   localparam logic [OUT_BITS-1:0] Full = '1;

   logic                 adv;
   logic [Lat-1:0]       vld_ff;

   logic [wtsl_pkg::Q30_W-1:0] lobe_val [Lobes];
   logic signed [42:0]   lobe_ext [Lobes];

   logic signed [42:0]   axis1000_ff [3];
   logic signed [42:0]   axis1000_in [3];
   logic [42:0]          mag1000 [3];
   logic [42:0]          rnd1000 [3];
   logic [37:0]          num_ff [3];
   logic                 neg_ff [3];
   logic [1:0]           negd_ff [3];
   logic [30:0]          axis_q [3];
   logic signed [31:0]   axis_ff [3];
   logic signed [31:0]   axis_in [3];
   logic signed [57:0]   prod_ff [3][3];
   logic signed [59:0]   sum_ff [3];
   logic signed [59:0]   sum_rnd [3];
   logic [46:0]          snum_ff [3];
   logic                 pos_ff [3];
   logic                 full_ff [3];
   logic [1:0]           posd_ff [3];
   logic [1:0]           fulld_ff [3];
   logic [29:0]          c30 [3];
   logic [30+OUT_BITS-1:0] scaled [3];
   logic [OUT_BITS-1:0]  chan_ff [3];
   logic [OUT_BITS-1:0]  chan_in [3];

   // advance while the output slot is empty or being taken
   assign adv       = !vld_ff[Lat-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   genvar g;
   for (g = 0; g < Lobes; g++) begin : g_lobe
      wtsl_lobe #(
         .WAVE_FRAC_BITS (WAVE_FRAC_BITS),
         .LOBE           (g)
      ) u_lobe (
         .clock      (clock),
         .adv        (adv),
         .wavelength (req_wavelength),
         .value      (lobe_val[g])
      );
      assign lobe_ext[g] = $signed({12'd0, lobe_val[g]});
   end

   always_comb begin
      axis1000_in[0] = wtsl_pkg::LOBE_AMP[0] * lobe_ext[0]
                     + wtsl_pkg::LOBE_AMP[1] * lobe_ext[1]
                     + wtsl_pkg::LOBE_AMP[2] * lobe_ext[2];
      axis1000_in[1] = wtsl_pkg::LOBE_AMP[3] * lobe_ext[3]
                     + wtsl_pkg::LOBE_AMP[4] * lobe_ext[4];
      axis1000_in[2] = wtsl_pkg::LOBE_AMP[5] * lobe_ext[5]
                     + wtsl_pkg::LOBE_AMP[6] * lobe_ext[6];
   end

   // round half away from zero: work on the magnitude, divide by 8 then 125
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         mag1000[a] = axis1000_ff[a][42] ? 43'(-axis1000_ff[a]) : 43'(axis1000_ff[a]);
         rnd1000[a] = mag1000[a] + wtsl_pkg::AMP_HALF;
         axis_in[a] = negd_ff[a][1] ? -$signed({1'b0, axis_q[a]})
                                    :  $signed({1'b0, axis_q[a]});
      end
   end

   for (g = 0; g < 3; g++) begin : g_axis
      wtsl_cmul #(
         .IN_W  (38),
         .M_W   (39),
         .MUL   (wtsl_pkg::RECIP_125),
         .SHIFT (wtsl_pkg::SHIFT_125),
         .OUT_W (31)
      ) u_adiv (
         .clock (clock),
         .adv   (adv),
         .din   (num_ff[g]),
         .dout  (axis_q[g])
      );

      wtsl_cmul #(
         .IN_W  (47),
         .M_W   (48),
         .MUL   (wtsl_pkg::RECIP_78125),
         .SHIFT (wtsl_pkg::SHIFT_78125),
         .OUT_W (30)
      ) u_mdiv (
         .clock (clock),
         .adv   (adv),
         .din   (snum_ff[g]),
         .dout  (c30[g])
      );
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_rnd[r] = sum_ff[r] + wtsl_pkg::MAT_HALF;
         scaled[r]  = c30[r] * Full + (30 + OUT_BITS)'(32'h2000_0000);
         if (!posd_ff[r][1]) begin
            chan_in[r] = '0;
         end else if (fulld_ff[r][1]) begin
            chan_in[r] = Full;
         end else begin
            chan_in[r] = scaled[r][30 +: OUT_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            axis1000_ff[a] <= axis1000_in[a];
            neg_ff[a]      <= axis1000_ff[a][42];
            num_ff[a]      <= rnd1000[a][40:3];
            negd_ff[a]     <= {negd_ff[a][0], neg_ff[a]};
            axis_ff[a]     <= axis_in[a];
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= wtsl_pkg::XYZ_TO_RGB[r][c] * axis_ff[c];
            end
            sum_ff[r]   <= prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2];
            pos_ff[r]   <= sum_ff[r] > 0;
            full_ff[r]  <= sum_ff[r] >= wtsl_pkg::SAT_LIMIT;
            snum_ff[r]  <= sum_rnd[r][53:7];
            posd_ff[r]  <= {posd_ff[r][0], pos_ff[r]};
            fulld_ff[r] <= {fulld_ff[r][0], full_ff[r]};
            chan_ff[r]  <= chan_in[r];
         end
      end
   end

   assign rsp_red   = chan_ff[0];
   assign rsp_green = chan_ff[1];
   assign rsp_blue  = chan_ff[2];

endmodule

[sim/wavelength_to_srgb_linear_core_test.sv]
// Self-checking testbench for wavelength_to_srgb_linear_core: drives random and
// edge-case wavelengths, predicts the RGB triple in a scoreboard class.
// Depends on wtsl_pkg and the core RTL.
`timescale 1ns / 1ps

class srgb_scoreboard;
   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rgb_type;

   rgb_type pending_rgb[$];
   int   mismatch_count;

   function longint unsigned exp_neg_q30(longint unsigned u_q16);
      longint unsigned n, r30, p, e;
      if (u_q16 >= (longint'(24) << 16)) return 0;
      n   = u_q16 >> 16;
      r30 = (u_q16 & 64'hFFFF) << 14;
      p   = 64'd1 << 30;
      for (int k = 14; k >= 1; k--)
         p = (64'd1 << 30) - ((r30 * p) >> 30) / k;
      e = p;
      for (longint unsigned i = 0; i < n; i++)
         e = (e * 64'd395007542 + (64'd1 << 29)) >> 30;
      return e;
   endfunction

   function longint unsigned lobe_q30(longint unsigned w, longint unsigned centre10,
                                      longint unsigned s_lo, longint unsigned s_hi);
      longint unsigned a, c, mag, s, den, t, u;
      a = w * 10;
      c = centre10 << 4;
      if (a < c) begin
         mag = c - a;
         s   = s_lo;
      end else begin
         mag = a - c;
         s   = s_hi;
      end
      den = 64'd100000 << 4;
      t   = (mag * s * 65536 + den / 2) / den;
      u   = (t * t + 65536) >> 17;
      return exp_neg_q30(u);
   endfunction

   function longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   function logic [15:0] channel(longint x, longint y, longint z,
                                 longint mx, longint my, longint mz);
      longint sum, c30;
      sum = mx * x + my * y + mz * z;
      if (sum <= 0) return 16'd0;
      c30 = round_div(sum, 10000000);
      if (c30 >= (longint'(1) << 30)) return 16'hFFFF;
      return 16'((c30 * 65535 + (longint'(1) << 29)) >>> 30);
   endfunction

   function void note_request(logic [13:0] wavelength);
      longint  w, x, y, z;
      rgb_type rgb;
      w = wavelength;
      x = round_div(362 * longint'(lobe_q30(w, 4420, 624, 374))
                  + 1056 * longint'(lobe_q30(w, 5998, 264, 323))
                  - 65 * longint'(lobe_q30(w, 5011, 490, 382)), 1000);
      y = round_div(821 * longint'(lobe_q30(w, 5688, 213, 247))
                  + 286 * longint'(lobe_q30(w, 5309, 613, 322)), 1000);
      z = round_div(1217 * longint'(lobe_q30(w, 4370, 845, 278))
                  + 681 * longint'(lobe_q30(w, 4590, 385, 725)), 1000);
      rgb.red   = channel(x, y, z, 32406255, -15372080, -4986286);
      rgb.green = channel(x, y, z, -9689307, 18757561, 415175);
      rgb.blue  = channel(x, y, z, 557101, -2040211, 10569959);
      pending_rgb.push_back(rgb);
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endfunction

   function void check_result(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
      rgb_type want;
      if (pending_rgb.size() == 0) begin
         report($sformatf("unexpected result %h %h %h", red, green, blue));
         return;
      end
      want = pending_rgb.pop_front();
      if (red !== want.red)
         report($sformatf("red got %h want %h", red, want.red));
      if (green !== want.green)
         report($sformatf("green got %h want %h", green, want.green));
      if (blue !== want.blue)
         report($sformatf("blue got %h want %h", blue, want.blue));
   endfunction
endclass

module wavelength_to_srgb_linear_core_test;

   localparam int LATENCY     = 67;
   localparam int CYCLE_LIMIT = 400000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [wtsl_pkg::WAVE_W-1:0]   req_wavelength;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [15:0]                   rsp_red;
   logic [15:0]                   rsp_green;
   logic [15:0]                   rsp_blue;

   srgb_scoreboard color_board;
   int  send_idle_pct;
   int  stall_pct;
   int  hold_off_cycles;
   longint cycle_count;

   wavelength_to_srgb_linear_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_wavelength(req_wavelength),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      color_board = new();
      req_valid = 1'b0;
      req_wavelength = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 0;
      cycle_count = 0;
   end

   // receiver: check results, stall at random or during a hold-off
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall)
         color_board.check_result(rsp_red, rsp_green, rsp_blue);
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // offer one request, idle at random first, hold until accepted
   task automatic send_request(logic [wtsl_pkg::WAVE_W-1:0] wavelength);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_wavelength <= wavelength;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      color_board.note_request(wavelength);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (color_board.pending_rgb.size() != 0) @(posedge clock);
   endtask

   function automatic logic [wtsl_pkg::WAVE_W-1:0] random_wavelength();
      // most samples in the visible band, where the lobes are active
      if ($urandom_range(3) != 0)
         return wtsl_pkg::WAVE_W'($urandom_range(380 * 16, 780 * 16));
      return wtsl_pkg::WAVE_W'($urandom);
   endfunction

   initial begin
      logic [wtsl_pkg::WAVE_W-1:0] directed[$];
      directed = '{14'd0, 14'h3FFF, 14'h2AAA, 14'h1555, 14'd7072, 14'd7071, 14'd9597,
                   14'd8018, 14'd9101, 14'd8494, 14'd6992, 14'd7344, 14'd6080,
                   14'd12480, 14'd8000, 14'd10000, 14'd9300, 14'd7500, 14'd1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i]);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 63 : 19) : 0;
         stall_pct     = (phase == 2) ? 63 : (phase == 3 ? 19 : 0);
         if (phase == 0) hold_off_cycles = 300;
         repeat (500) send_request(random_wavelength());
         drain();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (color_board.mismatch_count == 0 && color_board.pending_rgb.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
